@@ sv/scp_pkg.sv @@
// Shared constants, codes and pipeline control type for the shape pair collision test.
`default_nettype none
package scp_pkg;

  // Default field widths: Q16.4 coordinates, Q12.4 sizes
  localparam int COORD_BITS_DEF = 20;
  localparam int SIZE_BITS_DEF  = 16;

  // Shape kind codes
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  // Bits needed for a distance magnitude or radius in doubled units
  function automatic int mag_bits(input int coord_bits, input int size_bits);
    return ((coord_bits > size_bits) ? coord_bits : size_bits) + 3;
  endfunction

  // Control that travels down the pipeline with each word
  typedef struct packed {
    logic valid;     // stage holds a word
    logic box_pair;  // both shapes are boxes
    logic box_hit;   // interval overlap result for a box pair
  } scp_ctl_t;

endpackage
`default_nettype wire

@@ sv/scp_geom.sv @@
// Geometry stage: centres, clamping and per-axis distances, box pair overlap.
`default_nettype none
module scp_geom #(
  parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = scp_pkg::SIZE_BITS_DEF,
  localparam int MB = scp_pkg::mag_bits(COORD_BITS, SIZE_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         kind_a,
  input  logic signed [COORD_BITS-1:0] pos_a_x,
  input  logic signed [COORD_BITS-1:0] pos_a_y,
  input  logic        [SIZE_BITS-1:0]  size_a_w,
  input  logic        [SIZE_BITS-1:0]  size_a_h,
  input  logic                         kind_b,
  input  logic signed [COORD_BITS-1:0] pos_b_x,
  input  logic signed [COORD_BITS-1:0] pos_b_y,
  input  logic        [SIZE_BITS-1:0]  size_b_w,
  input  logic        [SIZE_BITS-1:0]  size_b_h,
  output scp_pkg::scp_ctl_t            ctl,
  output logic        [MB-1:0]         mag_x,
  output logic        [MB-1:0]         mag_y,
  output logic        [MB-1:0]         rad
);
  import scp_pkg::*;

  localparam int WB = MB + 1;

  logic signed [WB-1:0] ax_e, ay_e, bx_e, by_e;
  logic signed [WB-1:0] ax, ay, bx, by, aw, ah, bw, bh;
  logic signed [WB-1:0] acx, acy, bcx, bcy;
  logic signed [WB-1:0] lo_x, hi_x, lo_y, hi_y, cen_x, cen_y, r_sel;
  logic signed [WB-1:0] tx, ty, dx, dy;
  logic                 bb_hit;
  scp_ctl_t             ctl_next;

  // Double all positions so half sizes and centres stay integral
  always_comb begin
    ax_e = WB'(pos_a_x);
    ay_e = WB'(pos_a_y);
    bx_e = WB'(pos_b_x);
    by_e = WB'(pos_b_y);
    ax   = {ax_e[WB-2:0], 1'b0};
    ay   = {ay_e[WB-2:0], 1'b0};
    bx   = {bx_e[WB-2:0], 1'b0};
    by   = {by_e[WB-2:0], 1'b0};
    aw   = WB'(size_a_w);
    ah   = WB'(size_a_h);
    bw   = WB'(size_b_w);
    bh   = WB'(size_b_h);
    acx  = ax + aw;
    acy  = ay + ah;
    bcx  = bx + bw;
    bcy  = by + bh;
  end

  // Inclusive interval overlap on both axes
  assign bb_hit = !((ax > bx + (bw <<< 1)) || (ax + (aw <<< 1) < bx) ||
                    (ay + (ah <<< 1) < by) || (ay > by + (bh <<< 1)));

  // Pick the box to clamp against; a circle pair clamps to the other centre
  always_comb begin
    if (kind_a == KIND_BOX) begin
      lo_x  = ax;
      hi_x  = ax + (aw <<< 1);
      lo_y  = ay;
      hi_y  = ay + (ah <<< 1);
      cen_x = bcx;
      cen_y = bcy;
      r_sel = bw;
    end else if (kind_b == KIND_BOX) begin
      lo_x  = bx;
      hi_x  = bx + (bw <<< 1);
      lo_y  = by;
      hi_y  = by + (bh <<< 1);
      cen_x = acx;
      cen_y = acy;
      r_sel = aw;
    end else begin
      lo_x  = bcx;
      hi_x  = bcx;
      lo_y  = bcy;
      hi_y  = bcy;
      cen_x = acx;
      cen_y = acy;
      r_sel = aw + bw;
    end
  end

  // Clamp the centre and take the distance to the clamped point
  always_comb begin
    tx = (cen_x < lo_x) ? lo_x : ((cen_x > hi_x) ? hi_x : cen_x);
    ty = (cen_y < lo_y) ? lo_y : ((cen_y > hi_y) ? hi_y : cen_y);
    dx = cen_x - tx;
    dy = cen_y - ty;
  end

  always_comb begin
    ctl_next.valid    = in_valid;
    ctl_next.box_pair = (kind_a == KIND_BOX) && (kind_b == KIND_BOX);
    ctl_next.box_hit  = bb_hit;
  end

  // Hold the stage result
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_next.valid;
    end
    ctl.box_pair <= ctl_next.box_pair;
    ctl.box_hit  <= ctl_next.box_hit;
    mag_x        <= dx[WB-1] ? MB'(-dx) : MB'(dx);
    mag_y        <= dy[WB-1] ? MB'(-dy) : MB'(dy);
    rad          <= MB'(r_sel);
  end

endmodule
`default_nettype wire

@@ sv/scp_dist.sv @@
// Distance stage: exact squares, then sum and compare against the squared radius.
`default_nettype none
module scp_dist #(
  parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = scp_pkg::SIZE_BITS_DEF,
  localparam int MB = scp_pkg::mag_bits(COORD_BITS, SIZE_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  scp_pkg::scp_ctl_t ctl,
  input  logic [MB-1:0]     mag_x,
  input  logic [MB-1:0]     mag_y,
  input  logic [MB-1:0]     rad,
  output logic              done,
  output logic              overlap
);
  import scp_pkg::*;

  localparam int SQ = 2 * MB;

  scp_ctl_t        ctl_sq;
  logic [SQ-1:0]   sq_x, sq_y, sq_r;
  logic [SQ:0]     sq_sum;
  logic            overlap_next;

  // Square each term, one multiplier per term
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_sq.valid <= 1'b0;
    end else begin
      ctl_sq.valid <= ctl.valid;
    end
    ctl_sq.box_pair <= ctl.box_pair;
    ctl_sq.box_hit  <= ctl.box_hit;
    sq_x            <= SQ'(mag_x) * SQ'(mag_x);
    sq_y            <= SQ'(mag_y) * SQ'(mag_y);
    sq_r            <= SQ'(rad) * SQ'(rad);
  end

  // Compare the squared distance with the squared radius
  always_comb begin
    sq_sum       = {1'b0, sq_x} + {1'b0, sq_y};
    overlap_next = ctl_sq.box_pair ? ctl_sq.box_hit : (sq_sum <= {1'b0, sq_r});
  end

  // Drive the result word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_sq.valid;
    end
    overlap <= overlap_next;
  end

endmodule
`default_nettype wire

@@ sv/shape_pair_collision_test.sv @@
// Top level of the shape pair collision test.
// Tests two shapes (axis-aligned box or circle, each given by top-left corner
// and size) for touching or overlap. One word is taken in every clock cycle
// while busy is low, and busy is high only during reset. Each word gives one
// result through four register stages: input, clamp and distance, squaring,
// compare. done is high for exactly one cycle with overlap beside it, and the
// receiver cannot stall the pipeline.
`default_nettype none
module shape_pair_collision_test #(
  parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = scp_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_a,
  input  logic signed [COORD_BITS-1:0] pos_a_x,
  input  logic signed [COORD_BITS-1:0] pos_a_y,
  input  logic        [SIZE_BITS-1:0]  size_a_w,
  input  logic        [SIZE_BITS-1:0]  size_a_h,
  input  logic                         kind_b,
  input  logic signed [COORD_BITS-1:0] pos_b_x,
  input  logic signed [COORD_BITS-1:0] pos_b_y,
  input  logic        [SIZE_BITS-1:0]  size_b_w,
  input  logic        [SIZE_BITS-1:0]  size_b_h,
  output logic                         done,
  output logic                         overlap
);
  import scp_pkg::*;

  localparam int MB = mag_bits(COORD_BITS, SIZE_BITS);

  logic                         in_valid;
  logic                         r_kind_a, r_kind_b;
  logic signed [COORD_BITS-1:0] r_pos_a_x, r_pos_a_y, r_pos_b_x, r_pos_b_y;
  logic        [SIZE_BITS-1:0]  r_size_a_w, r_size_a_h, r_size_b_w, r_size_b_h;
  scp_ctl_t                     geom_ctl;
  logic        [MB-1:0]         geom_mag_x, geom_mag_y, geom_rad;

  // Refuse words only while in reset
  assign busy = rst;

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    r_kind_a   <= kind_a;
    r_pos_a_x  <= pos_a_x;
    r_pos_a_y  <= pos_a_y;
    r_size_a_w <= size_a_w;
    r_size_a_h <= size_a_h;
    r_kind_b   <= kind_b;
    r_pos_b_x  <= pos_b_x;
    r_pos_b_y  <= pos_b_y;
    r_size_b_w <= size_b_w;
    r_size_b_h <= size_b_h;
  end

  scp_geom #(
    .COORD_BITS(COORD_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_geom (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .kind_a  (r_kind_a),
    .pos_a_x (r_pos_a_x),
    .pos_a_y (r_pos_a_y),
    .size_a_w(r_size_a_w),
    .size_a_h(r_size_a_h),
    .kind_b  (r_kind_b),
    .pos_b_x (r_pos_b_x),
    .pos_b_y (r_pos_b_y),
    .size_b_w(r_size_b_w),
    .size_b_h(r_size_b_h),
    .ctl     (geom_ctl),
    .mag_x   (geom_mag_x),
    .mag_y   (geom_mag_y),
    .rad     (geom_rad)
  );

  scp_dist #(
    .COORD_BITS(COORD_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (geom_ctl),
    .mag_x  (geom_mag_x),
    .mag_y  (geom_mag_y),
    .rad    (geom_rad),
    .done   (done),
    .overlap(overlap)
  );

endmodule
`default_nettype wire

@@ sv/scp_checker.sv @@
// Port-level checks on the shape pair collision test, bound to its top level.
`default_nettype none
module scp_checker #(
  parameter int COORD_BITS = scp_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = scp_pkg::SIZE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         kind_a,
  input logic signed [COORD_BITS-1:0] pos_a_x,
  input logic signed [COORD_BITS-1:0] pos_a_y,
  input logic                         kind_b,
  input logic signed [COORD_BITS-1:0] pos_b_x,
  input logic signed [COORD_BITS-1:0] pos_b_y,
  input logic                         done,
  input logic                         overlap
);
  import scp_pkg::*;

  // Every accepted word yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word gave no result");

  // No result without an earlier accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without an accepted word");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  // Two boxes at the same corner always touch
  a_same_corner: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind_a == KIND_BOX) && (kind_b == KIND_BOX) &&
     (pos_a_x == pos_b_x) && (pos_a_y == pos_b_y)) |-> ##4 (done && overlap))
    else $error("coincident boxes reported apart");

endmodule

bind shape_pair_collision_test scp_checker #(
  .COORD_BITS(COORD_BITS),
  .SIZE_BITS (SIZE_BITS)
) u_scp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .kind_a (kind_a),
  .pos_a_x(pos_a_x),
  .pos_a_y(pos_a_y),
  .kind_b (kind_b),
  .pos_b_x(pos_b_x),
  .pos_b_y(pos_b_y),
  .done   (done),
  .overlap(overlap)
);
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking bench for the shape pair collision test: random and corner pairs, scored results.
`timescale 1ns / 1ps
module tb_top;
  import scp_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int SW          = SIZE_BITS_DEF;
  localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (CW - 1));
  localparam int SIZE_MAX    = (1 << SW) - 1;
  localparam int RAND_PAIRS  = 600;
  localparam int TAIL_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTS  = 40;

  // One word for the block, plus the sender's pacing after it
  typedef struct {
    logic                 kind_a;
    logic signed [CW-1:0] pos_a_x;
    logic signed [CW-1:0] pos_a_y;
    logic        [SW-1:0] size_a_w;
    logic        [SW-1:0] size_a_h;
    logic                 kind_b;
    logic signed [CW-1:0] pos_b_x;
    logic signed [CW-1:0] pos_b_y;
    logic        [SW-1:0] size_b_w;
    logic        [SW-1:0] size_b_h;
    int unsigned          gap_after;
    bit                   drain;
  } shape_pair_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic        overlap;
  shape_pair_t drv = '{default: '0};

  shape_pair_t pending_pairs_q[$];
  bit          expected_overlap_q[$];
  int          sent_cnt = 0;
  int          got_cnt = 0;
  int          idle_cnt = 0;
  int          stall_cycles = 0;
  int          errors = 0;

  shape_pair_collision_test #(
    .COORD_BITS(CW),
    .SIZE_BITS (SW)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .kind_a  (drv.kind_a),
    .pos_a_x (drv.pos_a_x),
    .pos_a_y (drv.pos_a_y),
    .size_a_w(drv.size_a_w),
    .size_a_h(drv.size_a_h),
    .kind_b  (drv.kind_b),
    .pos_b_x (drv.pos_b_x),
    .pos_b_y (drv.pos_b_y),
    .size_b_w(drv.size_b_w),
    .size_b_h(drv.size_b_h),
    .done    (done),
    .overlap (overlap)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // dx^2 + dy^2 <= r^2, exact at these widths
  function automatic bit reaches(input longint dx, input longint dy, input longint r);
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Box against circle, all figures in doubled units
  function automatic bit box_circle_hit(input longint bx, input longint by,
                                        input longint bw, input longint bh,
                                        input longint cx, input longint cy,
                                        input longint r);
    longint tx, ty;
    tx = clamp_to(cx, bx, bx + bw);
    ty = clamp_to(cy, by, by + bh);
    return reaches(cx - tx, cy - ty, r);
  endfunction

  // Expected overlap for one word; doubling keeps centres and radii integral
  function automatic bit collision_hit(input shape_pair_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    ax = 2 * longint'(p.pos_a_x);
    ay = 2 * longint'(p.pos_a_y);
    aw = longint'(p.size_a_w);
    ah = longint'(p.size_a_h);
    bx = 2 * longint'(p.pos_b_x);
    by = 2 * longint'(p.pos_b_y);
    bw = longint'(p.size_b_w);
    bh = longint'(p.size_b_h);
    if (p.kind_a == KIND_BOX && p.kind_b == KIND_BOX) begin
      return !(ax > bx + 2 * bw || ax + 2 * aw < bx ||
               ay + 2 * ah < by || ay > by + 2 * bh);
    end
    if (p.kind_a == KIND_BOX)
      return box_circle_hit(ax, ay, 2 * aw, 2 * ah, bx + bw, by + bh, bw);
    if (p.kind_b == KIND_BOX)
      return box_circle_hit(bx, by, 2 * bw, 2 * bh, ax + aw, ay + ah, aw);
    return reaches((ax + aw) - (bx + bw), (ay + ah) - (by + bh), aw + bw);
  endfunction

  function automatic logic signed [CW-1:0] fit_coord(input longint v);
    return CW'(clamp_to(v, COORD_MIN, COORD_MAX));
  endfunction

  // Mostly short pauses, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sizes: mostly small, with zero and full scale now and then
  function automatic int draw_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return SIZE_MAX;
    if (r < 7) return $urandom_range(0, 255);
    return $urandom_range(0, 4095);
  endfunction

  // Random pair: some fully random, most placed close enough to decide either way
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int          style, ax, ay, bx, by, aw, ah, bw, bh, reach_x, reach_y;
    p = '{default: '0};
    style = $urandom_range(0, 9);
    p.kind_a = 1'($urandom_range(0, 1));
    p.kind_b = 1'($urandom_range(0, 1));
    if (style < 3) begin
      p.pos_a_x = CW'($urandom);
      p.pos_a_y = CW'($urandom);
      p.size_a_w = SW'($urandom);
      p.size_a_h = SW'($urandom);
      p.pos_b_x = CW'($urandom);
      p.pos_b_y = CW'($urandom);
      p.size_b_w = SW'($urandom);
      p.size_b_h = SW'($urandom);
      return p;
    end
    aw = draw_size();
    ah = draw_size();
    bw = draw_size();
    bh = draw_size();
    ax = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    ay = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    reach_x = aw + bw + 4;
    reach_y = ah + bh + 4;
    bx = ax + int'($urandom_range(0, 2 * reach_x)) - reach_x;
    by = ay + int'($urandom_range(0, 2 * reach_y)) - reach_y;
    // graze the right edge of A by one step either way
    if (style == 9) bx = ax + aw + int'($urandom_range(0, 2)) - 1;
    p.pos_a_x = fit_coord(ax);
    p.pos_a_y = fit_coord(ay);
    p.size_a_w = SW'(aw);
    p.size_a_h = SW'(ah);
    p.pos_b_x = fit_coord(bx);
    p.pos_b_y = fit_coord(by);
    p.size_b_w = SW'(bw);
    p.size_b_h = SW'(bh);
    return p;
  endfunction

  task automatic add_pair(input logic ka, input int ax, input int ay, input int aw,
                          input int ah, input logic kb, input int bx, input int by,
                          input int bw, input int bh);
    shape_pair_t p;
    p.kind_a = ka;
    p.pos_a_x = CW'(ax);
    p.pos_a_y = CW'(ay);
    p.size_a_w = SW'(aw);
    p.size_a_h = SW'(ah);
    p.kind_b = kb;
    p.pos_b_x = CW'(bx);
    p.pos_b_y = CW'(by);
    p.size_b_w = SW'(bw);
    p.size_b_h = SW'(bh);
    p.gap_after = draw_gap();
    p.drain = 1'b0;
    pending_pairs_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
  endtask

  // Drive words from the pending queue; hold while busy, pause on gaps and drains
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        sent_cnt++;
        idle_cnt = drv.gap_after;
      end
      if (idle_cnt > 0) begin
        idle_cnt--;
        start <= 1'b0;
      end else if (pending_pairs_q.size() != 0 && pending_pairs_q[0].drain &&
                   sent_cnt != got_cnt) begin
        start <= 1'b0;
      end else if (pending_pairs_q.size() != 0) begin
        drv <= pending_pairs_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Score each result against the oldest prediction, then log the word taken
  always @(posedge clk) begin : monitor
    bit want;
    if (!rst) begin
      if (done) begin
        if (expected_overlap_q.size() == 0) begin
          report_mismatch($sformatf("result %0b with no word outstanding", overlap));
        end else begin
          want = expected_overlap_q.pop_front();
          if (overlap !== want)
            report_mismatch($sformatf("word %0d: overlap %0b, expected %0b",
                                      got_cnt, overlap, want));
        end
        got_cnt++;
      end
      if (start && !busy) expected_overlap_q.push_back(collision_hit(drv));
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("shape_pair_collision_test verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    shape_pair_t p;
    bit          steady;
    steady = 1'b0;

    // box against box: overlap, touching, one step apart, points, extremes
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_BOX, 8, 8, 16, 16);
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_BOX, 16, 0, 16, 16);
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_BOX, 17, 0, 16, 16);
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_BOX, 0, -17, 16, 16);
    add_pair(KIND_BOX, 5, 5, 0, 0, KIND_BOX, 5, 5, 0, 0);
    add_pair(KIND_BOX, 0, 0, 0, 32, KIND_BOX, 0, 10, 16, 4);
    add_pair(KIND_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
             KIND_BOX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
    add_pair(KIND_BOX, COORD_MAX, COORD_MAX, 0, 0,
             KIND_BOX, COORD_MAX - 1, COORD_MAX, SIZE_MAX, 0);
    // circle against circle: touching, one step apart, points, odd diameters
    add_pair(KIND_CIRCLE, 0, 0, 32, 32, KIND_CIRCLE, 32, 0, 32, 32);
    add_pair(KIND_CIRCLE, 0, 0, 32, 32, KIND_CIRCLE, 33, 0, 32, 32);
    add_pair(KIND_CIRCLE, 7, 7, 0, 0, KIND_CIRCLE, 7, 7, 0, 0);
    add_pair(KIND_CIRCLE, 0, 0, 1, 1, KIND_CIRCLE, 1, 0, 1, 1);
    // circle height shifts the centre only
    add_pair(KIND_CIRCLE, 0, 0, 32, 0, KIND_CIRCLE, 0, 17, 32, 32);
    add_pair(KIND_CIRCLE, 0, 0, 32, 2, KIND_CIRCLE, 0, 17, 32, 32);
    add_pair(KIND_CIRCLE, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
             KIND_CIRCLE, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
    // box against circle near a corner, both orders
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_CIRCLE, 14, 15, 10, 10);
    add_pair(KIND_CIRCLE, 14, 15, 10, 10, KIND_BOX, 0, 0, 16, 16);
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_CIRCLE, 14, 16, 10, 10);
    add_pair(KIND_CIRCLE, 14, 16, 10, 10, KIND_BOX, 0, 0, 16, 16);
    // centre inside the box, point circles, extremes
    add_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 40, 40, 4, 4);
    add_pair(KIND_BOX, 0, 0, 16, 16, KIND_CIRCLE, 8, 8, 0, 0);
    add_pair(KIND_BOX, COORD_MAX, COORD_MIN, SIZE_MAX, 0,
             KIND_CIRCLE, COORD_MAX, COORD_MIN, 0, 0);
    add_pair(KIND_CIRCLE, COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX,
             KIND_BOX, COORD_MIN, COORD_MAX, 0, 0);
    add_pair(KIND_CIRCLE, COORD_MAX, COORD_MAX, SIZE_MAX, 0,
             KIND_BOX, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
    pending_pairs_q[12].drain = 1'b1;

    // random pairs, with stretches of back-to-back words and periodic drains
    for (int i = 0; i < RAND_PAIRS; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      p = random_pair();
      p.gap_after = steady ? 0 : draw_gap();
      p.drain = (i % 120 == 60);
      pending_pairs_q.push_back(p);
    end

    // release reset, then wait for every word to go in and come back
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_pairs_q.size() != 0 || start || sent_cnt != got_cnt) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_overlap_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_overlap_q.size()));
    if (errors == 0) begin
      $display("shape_pair_collision_test verification clean");
    end else begin
      $display("shape_pair_collision_test verification failed");
    end
    $finish;
  end

endmodule

@@ shape_pair_collision_test.f @@
sv/scp_pkg.sv
sv/scp_geom.sv
sv/scp_dist.sv
sv/shape_pair_collision_test.sv
sv/scp_checker.sv
dv/tb_top.sv
